[hdl/tsp_branch_and_bound_search_assert.svh]
// Assertion macros used by the search block's module.
`ifndef TSP_BRANCH_AND_BOUND_SEARCH_ASSERT_SVH
`define TSP_BRANCH_AND_BOUND_SEARCH_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define TSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/tsp_pkg.sv]
// Package with shared constants and types of the tour search block.
package tsp_pkg;
  localparam int unsigned MaxVertices = 8;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned NoEdgeValue = 65535;
  localparam int unsigned LenBits     = 20;
  localparam int unsigned CountBits   = 13;

  localparam logic [0:0] CmdLoad  = 1'b0;
  localparam logic [0:0] CmdStart = 1'b1;

  localparam logic [0:0] RegVertexCount = 1'b0;
  localparam logic [0:0] RegStartVertex = 1'b1;

  typedef struct packed {
    logic [2:0]  vertex;
    logic [19:0] tour_length;
    logic [12:0] tours_found;
    logic        found;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [0:0]  command;
    logic [2:0]  from_vertex;
    logic [2:0]  to_vertex;
    logic [15:0] weight;
  } item_t;

  typedef struct packed {
    logic        index;
    logic [3:0]  data;
  } cfg_t;
endpackage

[hdl/tsp_if.sv]
// Valid/ready channel interface carrying a payload of generic type.
interface tsp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/tsp_branch_and_bound_search.sv]
// Top level of the branch-and-bound travelling-salesman search block.
// A search judges each candidate vertex by a matrix read, then the shared add and compare
// (S_READ, S_EVAL); a closing edge goes through S_READ, S_CLOSE and S_POP, and a backtrack
// through S_POP. Each result goes through S_EMIT and then S_WAIT until it is taken. One item
// is worked at a time and the input is not ready meanwhile. Reset is
// asynchronous and active low; it clears control state, sets the registers to 4 and 0.
module tsp_branch_and_bound_search #(
  parameter int unsigned MAX_VERTICES  = tsp_pkg::MaxVertices,
  parameter int unsigned WEIGHT_BITS   = tsp_pkg::WeightBits,
  parameter int unsigned NO_EDGE_VALUE = tsp_pkg::NoEdgeValue
) (
  input  logic clk_i,
  input  logic rst_ni,
  tsp_if.sink   in_if,
  tsp_if.sink   cfg_if,
  tsp_if.source out_if
);
  import tsp_pkg::*;
  `include "tsp_branch_and_bound_search_assert.svh"

  localparam int unsigned VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NB = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AB = 2 * VB;
  localparam logic [LenBits-1:0] LenInf = '1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_CLOSE = 7'b0001000,
    S_POP   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [WEIGHT_BITS-1:0] mem_q [MAX_VERTICES*MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] rd_q;
  logic [VB-1:0]  path_q [MAX_VERTICES];
  logic [LenBits-1:0] plen_q [MAX_VERTICES];
  logic [NB-1:0]  next_q [MAX_VERTICES];
  logic [VB-1:0]  best_q [MAX_VERTICES+1];
  logic [MAX_VERTICES-1:0] vis_q;
  logic [VB-1:0]  d_q;          // depth
  logic [NB-1:0]  c_q;          // candidate child
  logic [LenBits-1:0] bestlen_q;
  logic [CountBits-1:0] cnt_q;
  logic [3:0] vc_q;
  logic [2:0] sv_q;
  logic [NB-1:0] n_q;
  logic [VB-1:0] s_q;
  logic [NB-1:0] k_q;
  result_t res_q;
  logic out_v_q;

  // Shared adder and its compare.
  logic [LenBits-1:0] sum;
  logic [VB-1:0] cur;
  assign cur = path_q[d_q];
  assign sum = plen_q[d_q] + LenBits'(rd_q);

  logic at_leaf, zero_edge, no_edge;
  assign at_leaf   = (NB'(d_q) == n_q - NB'(1));
  assign no_edge   = (rd_q == WEIGHT_BITS'(NO_EDGE_VALUE));
  assign zero_edge = (rd_q == '0);

  logic item_acc, cfg_acc, out_acc;
  assign in_if.ready  = (state_q == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign item_acc = in_if.valid & in_if.ready;
  assign cfg_acc  = cfg_if.valid & cfg_if.ready;
  assign out_acc  = out_if.valid & out_if.ready;
  assign out_if.valid = out_v_q;
  assign out_if.data  = res_q;

  // Clamped vertex count.
  logic [NB-1:0] n_clamp;
  always_comb begin
    if (vc_q < 4'd2) n_clamp = NB'(2);
    else if (32'(vc_q) > MAX_VERTICES) n_clamp = NB'(MAX_VERTICES);
    else n_clamp = NB'(vc_q);
  end

  // Distance matrix: one write port for loads, one registered read port for the search.
  logic [AB-1:0] rd_addr;
  always_comb begin
    if (state_q == S_IDLE || at_leaf)
      rd_addr = {cur, s_q};
    else
      rd_addr = {cur, c_q[VB-1:0]};
  end
  always_ff @(posedge clk_i) begin
    if (item_acc && in_if.data.command == CmdLoad &&
        32'(in_if.data.from_vertex) < MAX_VERTICES && 32'(in_if.data.to_vertex) < MAX_VERTICES)
      mem_q[{VB'(in_if.data.from_vertex), VB'(in_if.data.to_vertex)}] <=
        WEIGHT_BITS'(in_if.data.weight);
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 4'd4;
      sv_q <= 3'd0;
    end else if (cfg_acc) begin
      if (cfg_if.data.index == RegVertexCount) vc_q <= cfg_if.data.data;
      else sv_q <= cfg_if.data.data[2:0];
    end
  end

  // Candidate check: c_q is still below the vertex count.
  logic cand_ok;
  assign cand_ok = (c_q < n_q);

  // The level is left when its partial length no longer beats the best tour or
  // when every candidate has been tried.
  logic eval_stop;
  assign eval_stop = !(plen_q[d_q] < bestlen_q) || !cand_ok;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (item_acc && in_if.data.command == CmdStart) begin
        if (32'(sv_q) >= 32'(n_clamp)) state_d = S_EMIT;
        else state_d = S_READ;
      end
      S_READ:  state_d = at_leaf ? S_CLOSE : S_EVAL;
      S_EVAL:  state_d = eval_stop ? S_POP : S_READ;
      S_CLOSE: state_d = S_POP;
      S_POP:   state_d = (d_q == '0) ? S_EMIT : S_READ;
      S_EMIT:  state_d = S_WAIT;
      S_WAIT:  if (out_acc) state_d = res_q.last ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      d_q <= '0;
      c_q <= '0;
      vis_q <= '0;
      bestlen_q <= LenInf;
      cnt_q <= '0;
      n_q <= NB'(2);
      s_q <= '0;
      k_q <= '0;
      res_q <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        path_q[i] <= '0;
        plen_q[i] <= '0;
        next_q[i] <= '0;
      end
      for (int i = 0; i <= MAX_VERTICES; i++) best_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (item_acc && in_if.data.command == CmdStart) begin
          n_q <= n_clamp;
          s_q <= VB'(sv_q);
          bestlen_q <= LenInf;
          cnt_q <= '0;
          k_q <= '0;
          d_q <= '0;
          c_q <= '0;
          vis_q <= MAX_VERTICES'(1) << sv_q;
          path_q[0] <= VB'(sv_q);
          plen_q[0] <= '0;
          for (int i = 0; i <= MAX_VERTICES; i++) best_q[i] <= '0;
        end
        S_READ: begin
          // Skip visited candidates while the read is in flight is not possible; the
          // candidate is judged in S_EVAL.
        end
        S_EVAL: begin
          if (!eval_stop) begin
            if (!vis_q[c_q[VB-1:0]] && !no_edge) begin
              next_q[d_q] <= c_q + NB'(1);
              path_q[d_q + VB'(1)] <= c_q[VB-1:0];
              plen_q[d_q + VB'(1)] <= sum;
              vis_q[c_q[VB-1:0]] <= 1'b1;
              d_q <= d_q + VB'(1);
              c_q <= '0;
            end else begin
              c_q <= c_q + NB'(1);
            end
          end
        end
        S_CLOSE: begin
          if (!zero_edge && !no_edge) begin
            cnt_q <= cnt_q + CountBits'(1);
            if (sum < bestlen_q) begin
              bestlen_q <= sum;
              for (int i = 0; i < MAX_VERTICES; i++)
                if (NB'(i) < n_q) best_q[i] <= path_q[i];
              best_q[n_q] <= s_q;
            end
          end
        end
        S_POP: begin
          if (d_q != '0) begin
            vis_q[cur] <= 1'b0;
            c_q <= next_q[d_q - VB'(1)];
            d_q <= d_q - VB'(1);
          end
        end
        S_EMIT: begin
          out_v_q <= 1'b1;
          if (32'(s_q) >= 32'(n_q) || bestlen_q == LenInf) begin
            res_q <= '{vertex: '0, tour_length: '0,
                       tours_found: (32'(s_q) >= 32'(n_q)) ? '0 : cnt_q,
                       found: 1'b0, last: 1'b1};
          end else begin
            res_q <= '{vertex: 3'(best_q[k_q]), tour_length: bestlen_q,
                       tours_found: cnt_q, found: 1'b1, last: (k_q == n_q)};
          end
          k_q <= k_q + NB'(1);
        end
        S_WAIT: if (out_acc) out_v_q <= 1'b0;
        default: ;
      endcase
    end
  end

  `TSP_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, state_q != S_IDLE, !in_if.ready,
                  "input ready while busy")
  `TSP_ASSERT_IMP(a_valid_in_wait, clk_i, rst_ni, out_if.valid, state_q == S_WAIT,
                  "result shown outside wait")
  `TSP_ASSERT_NXT(a_last_ends, clk_i, rst_ni, out_acc && res_q.last, state_q == S_IDLE,
                  "run did not end after last")
  `TSP_ASSERT_IMP(a_start_vis, clk_i, rst_ni,
                  state_q == S_READ || state_q == S_EVAL, vis_q[s_q],
                  "start vertex not marked")
endmodule
